/* rtl/mcdr_pkg.sv */
// mcdr_pkg: shared types and codes of the multi-channel dedup ring queue core
// no dependencies; used by mcdr_ctrl and the top level, not by mcdr_ram
`timescale 1ns / 1ps

package mcdr_pkg;

   // fixed field widths of the request and response words
   localparam int DEV_W = 2;
   localparam int KEY_W = 8;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // request word
   typedef struct packed {
      logic             op;
      logic [DEV_W-1:0] dev;
      logic [KEY_W-1:0] key;
   } req_type;

   // response word
   typedef struct packed {
      logic [KEY_W-1:0] key_out;
      logic             empty_res;
      logic             suppressed;
      logic             dropped;
   } rsp_type;

   // outcome of one operation, handed from the queue control to the pipeline
   typedef struct packed {
      logic pop_hit;
      logic empty_res;
      logic suppressed;
      logic dropped;
   } flags_type;

endpackage

/* rtl/mcdr_ram.sv */
// mcdr_ram: generic simple dual-port ram, one write and one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module mcdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic                                         re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, output holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/mcdr_ctrl.sv */
// mcdr_ctrl: per-device write/read pointers, fill counts and last codes;
// decides each push or pop and issues the ring ram command. uses mcdr_pkg
`timescale 1ns / 1ps

module mcdr_ctrl #(
   parameter int NUM_DEVICES = 4,
   parameter int RING_DEPTH  = 8
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   accept,
   input  mcdr_pkg::req_type                                      req,
   output mcdr_pkg::flags_type                                    flags,
   output logic                                                   ram_we,
   output logic [$clog2(NUM_DEVICES*RING_DEPTH)-1:0]              ram_waddr,
   output logic [mcdr_pkg::KEY_W-1:0]                             ram_wdata,
   output logic                                                   ram_re,
   output logic [$clog2(NUM_DEVICES*RING_DEPTH)-1:0]              ram_raddr
);

   localparam int DEV_IW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int ADDR_W = $clog2(NUM_DEVICES * RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(RING_DEPTH);

   logic [PTR_W-1:0]          wp_ff   [NUM_DEVICES];
   logic [PTR_W-1:0]          wp_in   [NUM_DEVICES];
   logic [PTR_W-1:0]          rp_ff   [NUM_DEVICES];
   logic [PTR_W-1:0]          rp_in   [NUM_DEVICES];
   logic [PTR_W-1:0]          cnt_ff  [NUM_DEVICES];
   logic [PTR_W-1:0]          cnt_in  [NUM_DEVICES];
   logic [mcdr_pkg::KEY_W-1:0] last_ff [NUM_DEVICES];
   logic [mcdr_pkg::KEY_W-1:0] last_in [NUM_DEVICES];

   logic                       in_range;
   logic [DEV_IW-1:0]          dev_idx;
   logic [PTR_W-1:0]           sel_wp;
   logic [PTR_W-1:0]           sel_rp;
   logic [PTR_W-1:0]           sel_cnt;
   logic [mcdr_pkg::KEY_W-1:0] sel_last;
   logic [PTR_W-1:0]           upd_wp;
   logic [PTR_W-1:0]           upd_rp;
   logic [PTR_W-1:0]           upd_cnt;
   logic [mcdr_pkg::KEY_W-1:0] upd_last;
   logic                       upd;
   logic                       do_write;
   logic                       do_read;
   logic [PTR_W:0]             occ_sum;
   logic [PTR_W:0]             occ_wrap;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [DEV_IW-1:0] d,
                                                   input logic [PTR_W-1:0] s);
      return ADDR_W'(int'(d) * RING_DEPTH + int'(s));
   endfunction

   // select the addressed device
   assign in_range = (32'(req.dev) < NUM_DEVICES);
   assign dev_idx  = DEV_IW'(req.dev);
   assign sel_wp   = wp_ff[dev_idx];
   assign sel_rp   = rp_ff[dev_idx];
   assign sel_cnt  = cnt_ff[dev_idx];
   assign sel_last = last_ff[dev_idx];

   // push / pop decision
   always_comb begin
      flags    = '0;
      do_write = 1'b0;
      do_read  = 1'b0;
      upd      = 1'b0;
      upd_wp   = sel_wp;
      upd_rp   = sel_rp;
      upd_cnt  = sel_cnt;
      upd_last = sel_last;
      if (req.op == mcdr_pkg::OP_PUSH) begin
         if (in_range) begin
            if (sel_cnt != '0 && sel_last == req.key) begin
               flags.suppressed = 1'b1;
            end else begin
               do_write = 1'b1;
               upd      = 1'b1;
               upd_wp   = next_slot(sel_wp);
               upd_last = req.key;
               if (next_slot(sel_wp) == sel_rp) begin
                  // ring full: drop oldest
                  upd_rp        = next_slot(sel_rp);
                  flags.dropped = 1'b1;
               end else begin
                  upd_cnt = sel_cnt + 1'b1;
               end
            end
         end
      end else begin
         if (in_range && sel_cnt != '0) begin
            do_read       = 1'b1;
            upd           = 1'b1;
            flags.pop_hit = 1'b1;
            upd_rp        = next_slot(sel_rp);
            upd_cnt       = sel_cnt - 1'b1;
         end else begin
            flags.empty_res = 1'b1;
         end
      end
   end

   // ring ram command
   assign ram_we    = accept && do_write;
   assign ram_waddr = slot_addr(dev_idx, sel_wp);
   assign ram_wdata = req.key;
   assign ram_re    = accept && do_read;
   assign ram_raddr = slot_addr(dev_idx, sel_rp);

   // per-device state write-back
   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      if (accept && upd) begin
         wp_in[dev_idx]   = upd_wp;
         rp_in[dev_idx]   = upd_rp;
         cnt_in[dev_idx]  = upd_cnt;
         last_in[dev_idx] = upd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DEVICES; i++) begin
            wp_ff[i]   <= '0;
            rp_ff[i]   <= '0;
            cnt_ff[i]  <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   // occupancy seen from the pointers, for checking
   assign occ_sum  = {1'b0, sel_rp} + {1'b0, sel_cnt};
   assign occ_wrap = (occ_sum >= DEPTH_X) ? occ_sum - DEPTH_X : occ_sum;

   a_ptr_count_agree: assert property (@(posedge clock) disable iff (reset)
      in_range |-> (occ_wrap[PTR_W-1:0] == sel_wp))
      else $error("write pointer disagrees with read pointer plus fill count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      in_range |-> (sel_cnt <= LAST_SLOT))
      else $error("fill count beyond ring capacity");

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ring write and read in the same cycle");

   a_suppress_no_write: assert property (@(posedge clock) disable iff (reset)
      (accept && flags.suppressed) |=> (cnt_ff[$past(dev_idx)] == $past(sel_cnt)))
      else $error("suppressed push changed the fill count");

endmodule

/* rtl/multi_channel_dedup_ring_fifo_core.sv */
// multi_channel_dedup_ring_fifo_core: top level; queue control, ring ram and
// the two response stages. uses mcdr_pkg, mcdr_ctrl, mcdr_ram
`timescale 1ns / 1ps

// an accepted request word passes stage 1, then the response word register
// throughput: one push or pop per cycle unless stalled; state update is a single read-modify-write
//   of the addressed device's pointers, the ring ram takes one access per cycle
// reset (synchronous): clears all pointers, fill counts, last codes and stage valids;
//   ring contents are not cleared and need no clearing pass
module multi_channel_dedup_ring_fifo_core #(
   parameter int NUM_DEVICES = 4,
   parameter int RING_DEPTH  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mcdr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcdr_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(NUM_DEVICES * RING_DEPTH);

   logic                       accept;
   logic                       s1_adv;
   mcdr_pkg::flags_type        flags;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [mcdr_pkg::KEY_W-1:0] ram_wdata;
   logic                       ram_re;
   logic [ADDR_W-1:0]          ram_raddr;
   logic [mcdr_pkg::KEY_W-1:0] ram_rdata;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   mcdr_pkg::flags_type        s1_flags_ff;
   mcdr_pkg::flags_type        s1_flags_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   mcdr_pkg::rsp_type          rsp_data_ff;
   mcdr_pkg::rsp_type          rsp_data_in;

   // handshake
   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // queue control
   mcdr_ctrl #(
      .NUM_DEVICES (NUM_DEVICES),
      .RING_DEPTH  (RING_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .flags     (flags),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr)
   );

   // ring storage for all devices
   mcdr_ram #(
      .WIDTH (mcdr_pkg::KEY_W),
      .DEPTH (NUM_DEVICES * RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // stage 1: outcome flags while the ram read completes
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_flags_in = s1_flags_ff;
      if (req_ready) begin
         s1_valid_in = accept;
         s1_flags_in = flags;
      end
   end

   // stage 2: response word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_adv) begin
         rsp_valid_in           = s1_valid_ff;
         rsp_data_in.key_out    = s1_flags_ff.pop_hit ? ram_rdata : '0;
         rsp_data_in.empty_res  = s1_flags_ff.empty_res;
         rsp_data_in.suppressed = s1_flags_ff.suppressed;
         rsp_data_in.dropped    = s1_flags_ff.dropped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_flags_ff <= s1_flags_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.empty_res, rsp_data_ff.suppressed,
                                 rsp_data_ff.dropped}))
      else $error("more than one outcome flag in a response word");

   a_key_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.key_out != '0) |->
         (!rsp_data_ff.empty_res && !rsp_data_ff.suppressed && !rsp_data_ff.dropped))
      else $error("nonzero code on a response that is not a pop hit");

   a_read_data_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_flags_ff.pop_hit && !s1_adv) |=> $stable(ram_rdata))
      else $error("ring read data changed under a stalled stage 1");

endmodule
